### rtl/tmpg_pkg.sv
// Shared types, constants and the colour palette of the text-mode pixel generator.
package tmpg_pkg;

    // Default geometry, handed to the top level as parameter defaults
    localparam int COLS_DEF     = 80;
    localparam int ROWS_DEF     = 24;
    localparam int SCREEN_W_DEF = 1366;
    localparam int SCREEN_H_DEF = 768;
    localparam int CELL_W_DEF   = 14;
    localparam int CELL_H_DEF   = 20;

    // Request codes
    localparam logic [1:0] REQ_CELL  = 2'd0;
    localparam logic [1:0] REQ_FONT  = 2'd1;
    localparam logic [1:0] REQ_PIXEL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TERM_ENABLE   = 2'd0;
    localparam logic [1:0] CFG_CURSOR_ON     = 2'd1;
    localparam logic [1:0] CFG_CURSOR_COLUMN = 2'd2;
    localparam logic [1:0] CFG_CURSOR_LINE   = 2'd3;

    localparam logic [31:0] COLOR_BACKDROP = 32'hFF001020;
    localparam logic [31:0] COLOR_CURSOR   = 32'hFFAAFFAA;
    localparam int          CURSOR_ROWS    = 2;
    localparam logic [7:0]  SPACE_CODE     = 8'd32;
    localparam logic [7:0]  FIRST_PRINT    = 8'd32;
    localparam logic [7:0]  LAST_PRINT     = 8'd126;

    // Reciprocal division: q = (v * ceil(2^SHIFT / d)) >> SHIFT, exact for v < 4096, 5 <= d <= 32 (fits MUL_W)
    localparam int RECIP_SHIFT = 18;
    localparam int MUL_W       = 16;

    // Field widths, sized for the largest legal geometry
    localparam int POS_W  = 12;  // offset inside the grid
    localparam int COL_W  = 7;
    localparam int LINE_W = 6;
    localparam int SUB_W  = 5;   // pixel offset inside a cell
    localparam int SRC_W  = 3;   // glyph column or row
    localparam int CA_W   = 12;  // cell store address
    localparam int FA_W   = 10;  // font store address
    localparam int CD_W   = 16;  // cell entry: bg, fg, code

    localparam logic [31:0] PALETTE [16] = '{
        32'hFF000000, 32'hFFAA0000, 32'hFF00AA00, 32'hFFAA5500,
        32'hFF0000AA, 32'hFFAA00AA, 32'hFF00AAAA, 32'hFFAAAAAA,
        32'hFF555555, 32'hFFFF5555, 32'hFF55FF55, 32'hFFFFFF55,
        32'hFF5555FF, 32'hFFFF55FF, 32'hFF55FFFF, 32'hFFFFFFFF
    };

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] screen_x;
        logic [9:0]  screen_y;
        logic [6:0]  cell_column;
        logic [4:0]  cell_line;
        logic [7:0]  char_code;
        logic [3:0]  fg_index;
        logic [3:0]  bg_index;
        logic [6:0]  glyph_code;
        logic [2:0]  glyph_row;
        logic [7:0]  glyph_bits;
    } t_req;

    typedef struct packed {
        logic on;
        logic [6:0] column;
        logic [4:0] line;
    } t_cursor;

    typedef struct packed {
        logic valid;
        logic pixel;
        logic cell_wr;
        logic font_wr;
        logic blank;     // disabled or off screen: not drawn
        logic backdrop;  // outside the character grid
        logic cursor;    // inside the cursor underline
    } t_ctl;

    typedef struct packed {
        t_ctl              ctl;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic [SUB_W-1:0]  sub_x;
        logic [SUB_W-1:0]  sub_y;
        logic [SRC_W-1:0]  src_x;
        logic [SRC_W-1:0]  src_y;
        logic [CA_W-1:0]   cell_addr;
        logic [CD_W-1:0]   cell_data;
        logic [FA_W-1:0]   font_addr;
        logic [7:0]        font_data;
    } t_item;

endpackage

### rtl/tmpg_locate.sv
// Locate stages: grid offset, cell row and column, offset inside the cell.
module tmpg_locate #(
    parameter int COLS     = tmpg_pkg::COLS_DEF,
    parameter int ROWS     = tmpg_pkg::ROWS_DEF,
    parameter int SCREEN_W = tmpg_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = tmpg_pkg::SCREEN_H_DEF,
    parameter int CELL_W   = tmpg_pkg::CELL_W_DEF,
    parameter int CELL_H   = tmpg_pkg::CELL_H_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_req_valid,
    input  tmpg_pkg::t_req i_req,
    input  logic           i_term_enable,
    output tmpg_pkg::t_item o_item
);
    import tmpg_pkg::*;

    localparam int GRID_W = COLS * CELL_W;
    localparam int GRID_H = ROWS * CELL_H;
    localparam int ORG_X  = (SCREEN_W - GRID_W) / 2;
    localparam int ORG_Y  = (SCREEN_H - GRID_H) / 2;
    localparam logic signed [13:0] ORG_X_S  = 14'(ORG_X);
    localparam logic signed [13:0] ORG_Y_S  = 14'(ORG_Y);
    localparam logic signed [13:0] GRID_W_S = 14'(GRID_W);
    localparam logic signed [13:0] GRID_H_S = 14'(GRID_H);
    localparam logic [MUL_W-1:0] RECIP_X =
        MUL_W'(((1 << RECIP_SHIFT) + CELL_W - 1) / CELL_W);
    localparam logic [MUL_W-1:0] RECIP_Y =
        MUL_W'(((1 << RECIP_SHIFT) + CELL_H - 1) / CELL_H);

    t_item r_s1, r_s2, r_s3;
    t_item n_s1, n_s2, n_s3;
    logic signed [13:0] rx, ry;
    logic [POS_W+MUL_W-1:0] prod_x, prod_y;
    logic [POS_W-1:0] base_x, base_y;

    // Stage 1: screen to grid offset, bounds, write addresses
    always_comb begin
        n_s1 = '0;
        rx = $signed({3'b000, i_req.screen_x}) - ORG_X_S;
        ry = $signed({4'b0000, i_req.screen_y}) - ORG_Y_S;
        n_s1.ctl.valid   = i_req_valid;
        n_s1.ctl.pixel   = (i_req.req_type == REQ_PIXEL);
        n_s1.ctl.font_wr = (i_req.req_type == REQ_FONT);
        n_s1.ctl.cell_wr = (i_req.req_type == REQ_CELL) &&
                           ({1'b0, i_req.cell_column} < 8'(COLS)) &&
                           ({1'b0, i_req.cell_line} < 6'(ROWS));
        n_s1.ctl.blank   = !i_term_enable ||
                           ({1'b0, i_req.screen_x} >= 12'(SCREEN_W)) ||
                           ({2'b00, i_req.screen_y} >= 12'(SCREEN_H));
        n_s1.ctl.backdrop = (rx < 0) || (rx >= GRID_W_S) || (ry < 0) || (ry >= GRID_H_S);
        n_s1.pos_x     = rx[POS_W-1:0];
        n_s1.pos_y     = ry[POS_W-1:0];
        n_s1.cell_addr = CA_W'(int'(i_req.cell_line) * COLS + int'(i_req.cell_column));
        n_s1.cell_data = {i_req.bg_index, i_req.fg_index, i_req.char_code};
        n_s1.font_addr = {i_req.glyph_code, i_req.glyph_row};
        n_s1.font_data = i_req.glyph_bits;
    end

    // Stage 2: cell column and row by reciprocal multiply
    always_comb begin
        n_s2 = r_s1;
        prod_x = r_s1.pos_x * RECIP_X;
        prod_y = r_s1.pos_y * RECIP_Y;
        n_s2.col  = prod_x[RECIP_SHIFT +: COL_W];
        n_s2.line = prod_y[RECIP_SHIFT +: LINE_W];
    end

    // Stage 3: offset inside the cell and the cell store address
    always_comb begin
        n_s3 = r_s2;
        base_x = POS_W'(int'(r_s2.col) * CELL_W);
        base_y = POS_W'(int'(r_s2.line) * CELL_H);
        n_s3.sub_x = SUB_W'(r_s2.pos_x - base_x);
        n_s3.sub_y = SUB_W'(r_s2.pos_y - base_y);
        if (r_s2.ctl.pixel) begin
            n_s3.cell_addr = CA_W'(int'(r_s2.line) * COLS + int'(r_s2.col));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.ctl <= '0;
            r_s2.ctl <= '0;
            r_s3.ctl <= '0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_item = r_s3;

    a_cell_wr_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3.ctl.valid && r_s3.ctl.cell_wr) |-> (r_s3.cell_addr < CA_W'(COLS * ROWS)))
        else $error("cell write address beyond the grid");

endmodule

### rtl/tmpg_cell_stage.sv
// Cell store stage: cell memory access, glyph sampling position and cursor test.
module tmpg_cell_stage #(
    parameter int COLS   = tmpg_pkg::COLS_DEF,
    parameter int ROWS   = tmpg_pkg::ROWS_DEF,
    parameter int CELL_W = tmpg_pkg::CELL_W_DEF,
    parameter int CELL_H = tmpg_pkg::CELL_H_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  tmpg_pkg::t_item   i_item,
    input  tmpg_pkg::t_cursor i_cursor,
    output tmpg_pkg::t_item   o_item
);
    import tmpg_pkg::*;

    localparam int DEPTH = COLS * ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [MUL_W-1:0] RECIP_X =
        MUL_W'(((1 << RECIP_SHIFT) + CELL_W - 1) / CELL_W);
    localparam logic [MUL_W-1:0] RECIP_Y =
        MUL_W'(((1 << RECIP_SHIFT) + CELL_H - 1) / CELL_H);
    localparam logic [SUB_W-1:0] CURSOR_TOP = SUB_W'(CELL_H - CURSOR_ROWS);

    logic [CD_W-1:0] cell_mem [DEPTH];
    logic [CD_W-1:0] r_rdata;
    t_item r_item, n_item;
    logic [8+MUL_W-1:0] prod_x, prod_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_item.ctl.valid && i_item.ctl.cell_wr) begin
                cell_mem[i_item.cell_addr[AW-1:0]] <= i_item.cell_data;
            end
            r_rdata <= cell_mem[i_item.cell_addr[AW-1:0]];
        end
    end

    // Nearest-neighbour source column and row: (sub * 8) / cell size
    always_comb begin
        n_item = i_item;
        prod_x = {i_item.sub_x, 3'b000} * RECIP_X;
        prod_y = {i_item.sub_y, 3'b000} * RECIP_Y;
        n_item.src_x = prod_x[RECIP_SHIFT +: SRC_W];
        n_item.src_y = prod_y[RECIP_SHIFT +: SRC_W];
        n_item.ctl.cursor = i_item.ctl.pixel && i_cursor.on &&
                            (i_item.col == i_cursor.column) &&
                            (i_item.line == {1'b0, i_cursor.line}) &&
                            (i_item.sub_y >= CURSOR_TOP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.ctl <= '0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    always_comb begin
        o_item = r_item;
        o_item.cell_data = r_rdata;
    end

    a_cursor_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item.ctl.cursor |-> (r_item.ctl.pixel && (r_item.sub_y >= CURSOR_TOP)))
        else $error("cursor flag outside the underline rows");

endmodule

### rtl/tmpg_glyph_stage.sv
// Glyph stage: printable-code mapping and font memory access.
module tmpg_glyph_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  tmpg_pkg::t_item i_item,
    output tmpg_pkg::t_item o_item
);
    import tmpg_pkg::*;

    logic [7:0] font_mem [1 << FA_W];
    logic [7:0] r_bits;
    t_item r_item;
    logic [7:0] code;
    logic [FA_W-1:0] addr;

    always_comb begin
        code = i_item.cell_data[7:0];
        if (code < FIRST_PRINT || code > LAST_PRINT) begin
            code = SPACE_CODE;
        end
        if (i_item.ctl.font_wr) begin
            addr = i_item.font_addr;
        end else begin
            addr = {code[6:0], i_item.src_y};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_item.ctl.valid && i_item.ctl.font_wr) begin
                font_mem[addr] <= i_item.font_data;
            end
            r_bits <= font_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.ctl <= '0;
        end else if (i_en) begin
            r_item <= i_item;
        end
    end

    always_comb begin
        o_item = r_item;
        o_item.font_data = r_bits;
    end

endmodule

### rtl/text_mode_pixel_generator.sv
// Top level of the text-mode pixel generator: request register, pipeline, result register.
// A pixel request passes the request register, the locate, cell and glyph stages and the
//   result register. Throughput: one request per cycle unless stalled, writes and pixel
//   queries alike; the cell memory read and the dependent font memory read set the pipeline depth.
// Reset clears the configuration registers and every valid flag; the cell and font
//   memories are not cleared and hold nothing defined until written.
module text_mode_pixel_generator #(
    parameter int COLS     = tmpg_pkg::COLS_DEF,
    parameter int ROWS     = tmpg_pkg::ROWS_DEF,
    parameter int SCREEN_W = tmpg_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = tmpg_pkg::SCREEN_H_DEF,
    parameter int CELL_W   = tmpg_pkg::CELL_W_DEF,
    parameter int CELL_H   = tmpg_pkg::CELL_H_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [10:0] i_screen_x,
    input  logic [9:0]  i_screen_y,
    input  logic [6:0]  i_cell_column,
    input  logic [4:0]  i_cell_line,
    input  logic [7:0]  i_char_code,
    input  logic [3:0]  i_fg_index,
    input  logic [3:0]  i_bg_index,
    input  logic [6:0]  i_glyph_code,
    input  logic [2:0]  i_glyph_row,
    input  logic [7:0]  i_glyph_bits,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_pixel_color,
    output logic        o_pixel_drawn,
    // configuration port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    import tmpg_pkg::*;

    // Configuration registers
    logic    r_term_enable;
    t_cursor r_cursor;

    // Request register (stage 0)
    logic r_req_valid;
    t_req r_req;

    t_item s3_item, s4_item, s5_item;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_out_color;
    logic        r_out_drawn;
    logic [31:0] n_out_color;
    logic        n_out_drawn;

    logic head_result;
    logic en;
    logic glyph_bit;

    // The whole pipeline moves together. Hold it only when a pixel result sits at
    // the head and the result register is full and stalled; a write or a bubble at
    // the head never blocks, so requests keep flowing while a result waits.
    assign head_result = s5_item.ctl.valid && s5_item.ctl.pixel;
    assign en          = !(r_out_valid && i_stall && head_result);
    assign o_stall     = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_enable <= 1'b0;
            r_cursor      <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TERM_ENABLE:   r_term_enable   <= i_cfg_data[0];
                CFG_CURSOR_ON:     r_cursor.on     <= i_cfg_data[0];
                CFG_CURSOR_COLUMN: r_cursor.column <= i_cfg_data;
                CFG_CURSOR_LINE:   r_cursor.line   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Capture the request; a stalled request holds because en is low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (en) begin
            r_req_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req.req_type    <= i_req_type;
            r_req.screen_x    <= i_screen_x;
            r_req.screen_y    <= i_screen_y;
            r_req.cell_column <= i_cell_column;
            r_req.cell_line   <= i_cell_line;
            r_req.char_code   <= i_char_code;
            r_req.fg_index    <= i_fg_index;
            r_req.bg_index    <= i_bg_index;
            r_req.glyph_code  <= i_glyph_code;
            r_req.glyph_row   <= i_glyph_row;
            r_req.glyph_bits  <= i_glyph_bits;
        end
    end

    // Stages 1 to 3: where on the grid the pixel falls
    tmpg_locate #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H),
        .CELL_W   (CELL_W),
        .CELL_H   (CELL_H)
    ) u_locate (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_req_valid   (r_req_valid),
        .i_req         (r_req),
        .i_term_enable (r_term_enable),
        .o_item        (s3_item)
    );

    // Stage 4: cell entry read or write, sampling position, cursor
    tmpg_cell_stage #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .CELL_W (CELL_W),
        .CELL_H (CELL_H)
    ) u_cell (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_item   (s3_item),
        .i_cursor (r_cursor),
        .o_item   (s4_item)
    );

    // Stage 5: glyph row read or font write
    tmpg_glyph_stage u_glyph (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_item  (s4_item),
        .o_item  (s5_item)
    );

    // Colour selection, in priority order: not drawn, backdrop, cursor, glyph
    always_comb begin
        glyph_bit = s5_item.font_data[s5_item.src_x];
        if (s5_item.ctl.blank) begin
            n_out_color = '0;
            n_out_drawn = 1'b0;
        end else if (s5_item.ctl.backdrop) begin
            n_out_color = COLOR_BACKDROP;
            n_out_drawn = 1'b1;
        end else if (s5_item.ctl.cursor) begin
            n_out_color = COLOR_CURSOR;
            n_out_drawn = 1'b1;
        end else if (glyph_bit) begin
            n_out_color = PALETTE[s5_item.cell_data[11:8]];
            n_out_drawn = 1'b1;
        end else begin
            n_out_color = PALETTE[s5_item.cell_data[15:12]];
            n_out_drawn = 1'b1;
        end
    end

    // Load a new result when one arrives; drop the old one once it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && head_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && head_result) begin
            r_out_color <= n_out_color;
            r_out_drawn <= n_out_drawn;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_color = r_out_color;
    assign o_pixel_drawn = r_out_drawn;

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s5_item.ctl.valid |->
            $onehot0({s5_item.ctl.pixel, s5_item.ctl.cell_wr, s5_item.ctl.font_wr}))
        else $error("request carries more than one kind");

    a_undrawn_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_drawn) |-> (r_out_color == '0))
        else $error("undrawn pixel with a non-zero colour");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(head_result))
        else $error("result raised without a pixel request at the head");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall && head_result) |=> (r_out_valid && $stable(r_out_color)))
        else $error("waiting result overwritten");

endmodule
